// File: hdl/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER_AT(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: hdl/tgarle_pkg.sv
// types, constants and register indexes for the tga run-length decoder
`timescale 1ns / 1ps

package tgarle_pkg;

	localparam int BYTE_W    = 8;
	localparam int PIXEL_W   = 32;
	localparam int ACC_W     = 24;
	localparam int COUNT_W   = 8;
	localparam int DIM_W     = 16;
	localparam int TOTAL_W   = 32;
	localparam int PB_W      = 3;
	localparam int IDX_W     = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// header byte fields
	localparam int RUN_FLAG_BIT = 7;
	localparam logic [6:0] COUNT_MASK = 7'h7F;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	// effective configuration seen by the decoder
	typedef struct packed {
		logic [PB_W-1:0]    pix_bytes;
		logic [TOTAL_W-1:0] image_total;
	} cfg_t;

	// one result item
	typedef struct packed {
		logic [PIXEL_W-1:0] pixel_value;
		logic [COUNT_W-1:0] repeat_count;
		logic               image_done;
		logic               overrun;
	} result_t;

endpackage

// File: hdl/tgarle_if.sv
// valid/ready channel interfaces for stream bytes and decoded pixels
`timescale 1ns / 1ps

interface tgarle_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink (input valid, input stream_byte, output ready);
endinterface

interface tgarle_pix_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_value;
	logic [7:0]  repeat_count;
	logic        image_done;
	logic        overrun;

	modport source (output valid, output pixel_value, output repeat_count,
		output image_done, output overrun, input ready);
	modport sink (input valid, input pixel_value, input repeat_count,
		input image_done, input overrun, output ready);
endinterface

// File: hdl/tgarle_cfg.sv
// configuration registers and effective pixel size and image total
`timescale 1ns / 1ps

module tgarle_cfg import tgarle_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	logic [PB_W-1:0]  pix_bytes_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [DIM_W-1:0] width_eff;
	logic [DIM_W-1:0] height_eff;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_bytes_q <= 3'd3;
			width_q     <= 16'd1;
			height_q    <= 16'd1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PIXEL_BYTES:  pix_bytes_q <= cfg_wdata[PB_W-1:0];
				REG_IMAGE_WIDTH:  width_q     <= cfg_wdata[DIM_W-1:0];
				REG_IMAGE_HEIGHT: height_q    <= cfg_wdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// zero dimensions act as one
	assign width_eff  = (width_q == '0) ? 16'd1 : width_q;
	assign height_eff = (height_q == '0) ? 16'd1 : height_q;

	// zero bytes acts as one, five to seven act as four; image total
	always_comb begin
		case (pix_bytes_q) inside
			3'd0:         cfg.pix_bytes = 3'd1;
			[3'd1:3'd4]:  cfg.pix_bytes = pix_bytes_q;
			default:      cfg.pix_bytes = 3'd4;
		endcase
		cfg.image_total = TOTAL_W'(width_eff) * TOTAL_W'(height_eff);
	end

endmodule

// File: hdl/tgarle_in_reg.sv
// input register holding one stream byte
`timescale 1ns / 1ps

module tgarle_in_reg import tgarle_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	tgarle_byte_if.sink       stream,
	input  logic              advance,
	output logic              valid_s1,
	output logic [BYTE_W-1:0] byte_s1
);

	// free when empty or when the held byte moves on this cycle
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1 <= stream.stream_byte;
		end
	end

endmodule

// File: hdl/tgarle_decode.sv
// packet and pixel decode state, one stream byte per cycle while the result register is not stalled
`timescale 1ns / 1ps

module tgarle_decode import tgarle_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  logic [BYTE_W-1:0] byte_s1,
	input  logic              advance,
	input  cfg_t              cfg,
	output logic              res_valid,
	output result_t           res
);

	logic                 expect_header_q;
	logic                 run_packet_q;
	logic [COUNT_W-1:0]   pkt_left_q;
	logic [IDX_W-1:0]     byte_idx_q;
	logic [ACC_W-1:0]     acc_q;
	logic [TOTAL_W-1:0]   remain_q;

	logic                 step;
	logic                 partial;
	logic [PIXEL_W-1:0]   shifted;
	logic [TOTAL_W-1:0]   pkt_ext;
	logic                 clamp;
	logic [TOTAL_W-1:0]   run_count;
	logic [TOTAL_W-1:0]   run_rem;
	logic                 raw_done;
	logic                 raw_ov;
	logic [TOTAL_W-1:0]   raw_rem;
	logic [COUNT_W-1:0]   pkt_dec;

	assign step = valid_s1 && advance;

	// pixel assembly, first byte in the low bits
	assign partial = ({1'b0, byte_idx_q} + 3'd1) < cfg.pix_bytes;
	assign shifted = PIXEL_W'(byte_s1) << {byte_idx_q, 3'b000};

	// run packet: clamp the count to what the image has left
	assign pkt_ext   = TOTAL_W'(pkt_left_q);
	assign clamp     = pkt_ext > remain_q;
	assign run_count = clamp ? remain_q : pkt_ext;
	assign run_rem   = remain_q - run_count;

	// raw packet: one pixel per result
	assign raw_done = remain_q <= 32'd1;
	assign raw_ov   = raw_done && (pkt_left_q > 8'd1);
	assign raw_rem  = raw_done ? '0 : remain_q - 32'd1;
	assign pkt_dec  = (pkt_left_q != '0) ? pkt_left_q - 8'd1 : '0;

	// result for a completed pixel
	assign res_valid = valid_s1 && !expect_header_q && !partial;
	always_comb begin
		res.pixel_value = PIXEL_W'(acc_q) | shifted;
		if (run_packet_q) begin
			res.repeat_count = run_count[COUNT_W-1:0];
			res.image_done   = (run_rem == '0);
			res.overrun      = clamp;
		end else begin
			res.repeat_count = 8'd1;
			res.image_done   = raw_done;
			res.overrun      = raw_ov;
		end
	end

	// state update per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_header_q <= 1'b1;
			run_packet_q    <= 1'b0;
			pkt_left_q      <= '0;
			byte_idx_q      <= '0;
			acc_q           <= '0;
			remain_q        <= '0;
		end else if (step) begin
			if (expect_header_q) begin
				if (remain_q == '0) begin
					remain_q <= cfg.image_total;
				end
				run_packet_q    <= byte_s1[RUN_FLAG_BIT];
				pkt_left_q      <= {1'b0, byte_s1[6:0] & COUNT_MASK} + 8'd1;
				byte_idx_q      <= '0;
				acc_q           <= '0;
				expect_header_q <= 1'b0;
			end else if (partial) begin
				acc_q      <= acc_q | shifted[ACC_W-1:0];
				byte_idx_q <= byte_idx_q + 2'd1;
			end else begin
				byte_idx_q <= '0;
				acc_q      <= '0;
				if (run_packet_q) begin
					remain_q        <= run_rem;
					pkt_left_q      <= '0;
					expect_header_q <= 1'b1;
				end else begin
					remain_q <= raw_rem;
					if (pkt_dec == '0 || raw_done) begin
						pkt_left_q      <= '0;
						expect_header_q <= 1'b1;
					end else begin
						pkt_left_q <= pkt_dec;
					end
				end
			end
		end
	end

endmodule

// File: hdl/tgarle_out_reg.sv
// result register driving the pixel channel
`timescale 1ns / 1ps

module tgarle_out_reg import tgarle_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         res_valid,
	input  result_t      res,
	output logic         advance,
	tgarle_pix_if.source pixels
);

	logic    valid_q;
	result_t res_q;

	// the register takes a new value when empty or being emptied
	assign advance = !valid_q || pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= res_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

	assign pixels.valid        = valid_q;
	assign pixels.pixel_value  = res_q.pixel_value;
	assign pixels.repeat_count = res_q.repeat_count;
	assign pixels.image_done   = res_q.image_done;
	assign pixels.overrun      = res_q.overrun;

endmodule

// File: hdl/tga_rle_pixel_decoder_top.sv
// top level of the tga run-length pixel decoder
`timescale 1ns / 1ps

// Decodes a tga run-length pixel stream (data after the 18-byte file header)
// one byte per cycle: a new byte is taken in every cycle the result side is
// not stalled. Each byte passes an input register, then the decode logic and
// the result register: the last byte of a pixel waits in the input register
// until the result register takes its result, which drives pixel valid.
// Header bytes and all but the last byte of a pixel give no result. A run
// pixel comes out once with its repeat count; raw pixels come out with a count
// of one. image_done marks the result that finishes width times height pixels,
// and the next byte starts a new image. Write the configuration only while no
// bytes are in flight; sizes take effect at the next image.

module tga_rle_pixel_decoder_top import tgarle_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	tgarle_byte_if.sink           stream,
	tgarle_pix_if.source          pixels
);

	cfg_t              cfg;
	logic              advance;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              res_valid;
	result_t           res;

	tgarle_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tgarle_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	tgarle_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1),
		.advance   (advance),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	tgarle_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.advance   (advance),
		.pixels    (pixels)
	);

endmodule

// File: hdl/tgarle_checker.sv
// port-level checks for the tga run-length decoder, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tgarle_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        stream_valid,
	input logic        stream_ready,
	input logic        pixels_valid,
	input logic        pixels_ready,
	input logic [31:0] pixel_value,
	input logic [7:0]  repeat_count,
	input logic        image_done,
	input logic        overrun
);

	// repeat count stays within one packet
	`ASSERT_NEVER_AT(a_count_range, clk, arst_n, pixels_valid && (repeat_count == 8'd0 || repeat_count > 8'd128), "repeat_count out of range")

	// a clamped packet always ends the image
	`ASSERT_AT(a_overrun_done, clk, arst_n, pixels_valid && overrun |-> image_done, "overrun without image_done")

	// a stalled item holds
	`ASSERT_AT(a_stall_hold, clk, arst_n, pixels_valid && !pixels_ready |=> pixels_valid && $stable(pixel_value) && $stable(repeat_count), "stalled item changed")

	// a new result follows an accepted stream byte
	`ASSERT_AT(a_latency, clk, arst_n, $rose(pixels_valid) |-> $past(stream_valid && stream_ready, 2), "result without a byte in flight")

endmodule

bind tga_rle_pixel_decoder_top tgarle_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.stream_valid (stream.valid),
	.stream_ready (stream.ready),
	.pixels_valid (pixels.valid),
	.pixels_ready (pixels.ready),
	.pixel_value  (pixels.pixel_value),
	.repeat_count (pixels.repeat_count),
	.image_done   (pixels.image_done),
	.overrun      (pixels.overrun)
);

// File: verif/tgarle_decode_check.sv
// checker for the tga run-length decoder: predicts each pixel item and compares
`timescale 1ns / 1ps

module tgarle_decode_check import tgarle_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	tgarle_byte_if                stream,
	tgarle_pix_if                 pixels,
	output int                    mismatches,
	output int                    pending_pixels,
	output logic                  image_idle
);

	// shadow copy of the configuration registers
	logic [PB_W-1:0]    pix_bytes_reg;
	logic [DIM_W-1:0]   width_reg;
	logic [DIM_W-1:0]   height_reg;

	// decode state
	logic               want_header;
	logic               in_run;
	logic [COUNT_W-1:0] pkt_left;
	logic [IDX_W-1:0]   byte_idx;
	logic [ACC_W-1:0]   acc;
	logic [TOTAL_W-1:0] pix_left;

	// pixel items predicted but not yet seen on the pixel channel
	result_t            expected_pixels[$];

	// advance the decoder by one stream byte, returns 1 when a pixel item is due
	function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output result_t r);
		int unsigned        pb;
		logic [TOTAL_W-1:0] w;
		logic [TOTAL_W-1:0] h;
		logic [TOTAL_W-1:0] cnt;
		bit                 done;
		pb = (pix_bytes_reg == 0) ? 1 : (pix_bytes_reg > 4) ? 4 : pix_bytes_reg;
		r = '0;

		// packet header, loads the image size when no image is open
		if (want_header) begin
			if (pix_left == 0) begin
				w = (width_reg == 0) ? 1 : width_reg;
				h = (height_reg == 0) ? 1 : height_reg;
				pix_left = w * h;
			end
			in_run = b[RUN_FLAG_BIT];
			pkt_left = {1'b0, b[6:0] & COUNT_MASK} + 8'd1;
			byte_idx = '0;
			acc = '0;
			want_header = 1'b0;
			return 1'b0;
		end

		// more bytes of this pixel to come
		if (byte_idx + 1 < pb) begin
			acc = acc | (ACC_W'(b) << (8 * byte_idx));
			byte_idx = byte_idx + 2'd1;
			return 1'b0;
		end

		r.pixel_value = {8'h00, acc} | (PIXEL_W'(b) << (8 * byte_idx));
		byte_idx = '0;
		acc = '0;

		if (in_run) begin
			// run pixel, clamped to what is left of the image
			cnt = TOTAL_W'(pkt_left);
			if (cnt > pix_left) begin
				cnt = pix_left;
				r.overrun = 1'b1;
			end
			pix_left = pix_left - cnt;
			r.repeat_count = cnt[COUNT_W-1:0];
			r.image_done = (pix_left == 0);
			pkt_left = '0;
			want_header = 1'b1;
		end else begin
			// raw pixel, the packet stops at the end of the image
			done = (pix_left <= 1);
			r.repeat_count = 8'd1;
			r.image_done = done;
			r.overrun = done && (pkt_left > 1);
			pix_left = done ? '0 : pix_left - 32'd1;
			pkt_left = (pkt_left != 0) ? pkt_left - 8'd1 : '0;
			if (pkt_left == 0 || done) begin
				pkt_left = '0;
				want_header = 1'b1;
			end
		end
		return 1'b1;
	endfunction

	task automatic report_field(input string field, input logic [PIXEL_W-1:0] want,
		input logic [PIXEL_W-1:0] got);
		$display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t seen;
		result_t want;
		result_t fresh;
		if (!arst_n) begin
			pix_bytes_reg = 3;
			width_reg = 1;
			height_reg = 1;
			want_header = 1'b1;
			in_run = 1'b0;
			pkt_left = '0;
			byte_idx = '0;
			acc = '0;
			pix_left = '0;
			expected_pixels.delete();
			mismatches = 0;
			pending_pixels = 0;
			image_idle = 1'b1;
		end else begin
			// register writes
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_PIXEL_BYTES:  pix_bytes_reg = cfg_wdata[PB_W-1:0];
					REG_IMAGE_WIDTH:  width_reg = cfg_wdata;
					REG_IMAGE_HEIGHT: height_reg = cfg_wdata;
					default: ;
				endcase
			end

			// compare an accepted pixel item with the oldest prediction
			if (pixels.valid && pixels.ready) begin
				seen.pixel_value = pixels.pixel_value;
				seen.repeat_count = pixels.repeat_count;
				seen.image_done = pixels.image_done;
				seen.overrun = pixels.overrun;
				if (expected_pixels.size() == 0) begin
					$display("%0t: pixel item with none expected, expected none actual %h",
						$time, seen);
					mismatches++;
				end else begin
					want = expected_pixels.pop_front();
					if (seen.pixel_value !== want.pixel_value)
						report_field("pixel_value", want.pixel_value, seen.pixel_value);
					if (seen.repeat_count !== want.repeat_count)
						report_field("repeat_count", want.repeat_count, seen.repeat_count);
					if (seen.image_done !== want.image_done)
						report_field("image_done", want.image_done, seen.image_done);
					if (seen.overrun !== want.overrun)
						report_field("overrun", want.overrun, seen.overrun);
				end
			end

			// predict from an accepted stream byte
			if (stream.valid && stream.ready) begin
				if (decode_byte(stream.stream_byte, fresh))
					expected_pixels = {expected_pixels, fresh};
			end

			pending_pixels = expected_pixels.size();
			image_idle = (pix_left == 0);
		end
	end

endmodule

// File: verif/tga_rle_pixel_decoder_top_tb.sv
// testbench top for the tga run-length decoder: stream stimulus, sink stalls and verdict
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_top_tb;
	import tgarle_pkg::*;

	localparam int BYTE_TARGET   = 1950;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 8;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int                    mismatches;
	int                    pending_pixels;
	logic                  image_idle;
	int                    cycles = 0;
	int                    bytes_sent = 0;
	bit                    src_pauses = 1'b0;
	bit                    snk_pauses = 1'b0;
	logic [PB_W-1:0]       pix_bytes_set = 3;

	tgarle_byte_if stream_ch ();
	tgarle_pix_if  pixel_ch ();

	tga_rle_pixel_decoder_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.stream    (stream_ch),
		.pixels    (pixel_ch)
	);

	tgarle_decode_check u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.stream         (stream_ch),
		.pixels         (pixel_ch),
		.mismatches     (mismatches),
		.pending_pixels (pending_pixels),
		.image_idle     (image_idle)
	);

	// 4 ns clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tga_rle_pixel_decoder_top_tb failed");
			$finish;
		end
	end

	// pixel sink, random wait before each item while sink pauses are on
	initial begin
		int gap;
		pixel_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = snk_pauses ? $urandom_range(0, 7) : 0;
			if (gap != 0) begin
				pixel_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pixel_ch.ready <= 1'b1;
			@(posedge clk);
			while (!(pixel_ch.valid && pixel_ch.ready)) @(posedge clk);
			@(negedge clk);
		end
	end

	// one stream byte, called and returning at a falling edge
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = src_pauses ? $urandom_range(0, 7) : 0;
		if (gap != 0) begin
			stream_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		stream_ch.valid <= 1'b1;
		stream_ch.stream_byte <= b;
		@(posedge clk);
		while (!stream_ch.ready) @(posedge clk);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_bytes(input logic [BYTE_W-1:0] seq[$]);
		foreach (seq[i]) send_byte(seq[i]);
	endtask

	// drop valid, wait for every predicted item, then let the pipeline drain
	task automatic settle();
		stream_ch.valid <= 1'b0;
		while (pending_pixels != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// register write; the caller lowers cfg_wr_en after the last one
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		if (idx == REG_PIXEL_BYTES)
			pix_bytes_set = data[PB_W-1:0];
		@(negedge clk);
	endtask

	// one packet with random content, sometimes cut short or replaced by a stray byte
	task automatic send_packet();
		int unsigned      pb;
		int unsigned      nbytes;
		int unsigned      sel;
		logic [BYTE_W-1:0] hdr;
		pb = (pix_bytes_set == 0) ? 1 : (pix_bytes_set > 4) ? 4 : pix_bytes_set;
		if ($urandom_range(0, 9) == 0) begin
			send_byte($urandom_range(0, 255));
			return;
		end
		sel = $urandom_range(0, 19);
		hdr[7] = $urandom_range(0, 1);
		hdr[6:0] = (sel < 14) ? $urandom_range(0, 7) :
			(sel < 19) ? $urandom_range(8, 31) : $urandom_range(32, 127);
		nbytes = hdr[7] ? pb : (hdr[6:0] + 1) * pb;
		if ($urandom_range(0, 15) == 0)
			nbytes = $urandom_range(0, nbytes);
		send_byte(hdr);
		repeat (nbytes) send_byte($urandom_range(0, 255));
	endtask

	initial begin
		int phase_len;
		int phase_start;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_PIXEL_BYTES;
		cfg_wdata = '0;
		stream_ch.valid = 1'b0;
		stream_ch.stream_byte = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings, one-pixel images: run, run past the end, raw past the end
		send_bytes('{8'h80, 8'h11, 8'h22, 8'h33, 8'hFF, 8'hC1, 8'hC2, 8'hC3,
			8'h01, 8'hAA, 8'hBB, 8'hCC, 8'h00, 8'hDD, 8'hEE, 8'hFF});
		settle();

		// zero byte count and zero height, raw packet that fills the image exactly
		cfg_write(REG_PIXEL_BYTES, 0);
		cfg_write(REG_IMAGE_WIDTH, 3);
		cfg_write(REG_IMAGE_HEIGHT, 0);
		cfg_wr_en <= 1'b0;
		send_bytes('{8'h82, 8'h01, 8'h85, 8'hA1, 8'h02, 8'h00, 8'hFF, 8'h5A});

		// random phases, each with its own settings and pauses
		while (bytes_sent < BYTE_TARGET) begin
			settle();
			if ($urandom_range(0, 3) != 0)
				cfg_write(REG_PIXEL_BYTES, $urandom_range(0, 7));
			if ($urandom_range(0, 7) == 0) begin
				cfg_write(REG_IMAGE_WIDTH, $urandom_range(0, 300));
				cfg_write(REG_IMAGE_HEIGHT, $urandom_range(0, 2));
			end else begin
				if ($urandom_range(0, 3) != 0)
					cfg_write(REG_IMAGE_WIDTH, $urandom_range(0, 8));
				if ($urandom_range(0, 3) != 0)
					cfg_write(REG_IMAGE_HEIGHT, $urandom_range(0, 8));
			end
			cfg_wr_en <= 1'b0;
			src_pauses = ($urandom_range(0, 3) != 0);
			snk_pauses = ($urandom_range(0, 3) != 0);
			phase_len = $urandom_range(40, 200);
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < phase_len)
				send_packet();
		end

		// finish the open image so the largest size takes effect
		settle();
		while (!image_idle) send_byte(8'hFF);
		settle();
		cfg_write(REG_PIXEL_BYTES, 1);
		cfg_write(REG_IMAGE_WIDTH, 16'hFFFF);
		cfg_write(REG_IMAGE_HEIGHT, 16'hFFFF);
		cfg_wr_en <= 1'b0;
		src_pauses = 1'b1;
		snk_pauses = 1'b1;
		send_bytes('{8'hFF, 8'h00, 8'h7F});
		repeat (128) send_byte($urandom_range(0, 255));
		settle();

		if (mismatches == 0)
			$display("tga_rle_pixel_decoder_top_tb passed");
		else
			$display("tga_rle_pixel_decoder_top_tb failed");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hdl
hdl/tgarle_pkg.sv
hdl/tgarle_if.sv
hdl/tgarle_cfg.sv
hdl/tgarle_in_reg.sv
hdl/tgarle_decode.sv
hdl/tgarle_out_reg.sv
hdl/tga_rle_pixel_decoder_top.sv
hdl/tgarle_checker.sv
verif/tgarle_decode_check.sv
verif/tga_rle_pixel_decoder_top_tb.sv
